/* rtl/core/ppd_pkg.sv */
`timescale 1ns / 1ps

package ppd_pkg;

    localparam int FRAME_WIDTH   = 320;
    localparam int FRAME_HEIGHT  = 240;
    localparam int PALETTE_DEPTH = 256;

    localparam int CODE_W   = 8;
    localparam int COLOR_W  = 16;
    localparam int DIM_W    = 10;
    localparam int FROW_W   = DIM_W + 1;
    localparam int BASE_W   = 21;
    localparam int OFFSET_W = 17;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        OP_PAL_WRITE = 2'd0,
        OP_PIXEL     = 2'd1,
        OP_SOF       = 2'd2,
        OP_UNUSED    = 2'd3
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH    = 2'd0,
        CFG_SRC_HEIGHT   = 2'd1,
        CFG_FRAME_ENABLE = 2'd2,
        CFG_NONE         = 2'd3
    } t_cfg_index;

    // palette memory access for one accepted word
    typedef struct packed {
        logic               we;
        logic [CODE_W-1:0]  waddr;
        logic [COLOR_W-1:0] wdata;
        logic               re;
        logic [CODE_W-1:0]  raddr;
    } t_pal_req;

    // placement of one pixel's framebuffer writes
    typedef struct packed {
        logic [FROW_W-1:0] frow;
        logic [DIM_W-1:0]  colbase;
        logic              hdbl;
        logic [2:0]        nwr;
        logic              zero_color;
    } t_job;

endpackage

/* rtl/core/ppd_palette_ram.sv */
`timescale 1ns / 1ps

module ppd_palette_ram (
    input  logic                 i_clk,
    input  ppd_pkg::t_pal_req    i_req,
    output logic [15:0]          o_rdata
);
    import ppd_pkg::*;

    logic [COLOR_W-1:0] r_mem [0:PALETTE_DEPTH-1];
    logic [COLOR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/ppd_sequencer.sv */
`timescale 1ns / 1ps

module ppd_sequencer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [1:0]        i_opcode,
    input  logic [7:0]        i_entry_index,
    input  logic [15:0]       i_entry_color,
    input  logic [7:0]        i_pixel_code,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [9:0]        i_cfg_data,
    output ppd_pkg::t_pal_req o_pal_req,
    output logic              o_job_valid,
    output ppd_pkg::t_job     o_job
);
    import ppd_pkg::*;

    logic [DIM_W-1:0] r_src_width, r_src_height;
    logic             r_frame_enable;
    logic [DIM_W-1:0] r_col, r_row, n_col, n_row;

    logic              is_pixel, in_height, col_ok, vdbl, hdbl, fits;
    logic [FROW_W-1:0] frow;
    logic [FROW_W:0]   frow_next;
    logic [1:0]        nrows;
    logic [2:0]        nwr;
    logic [DIM_W-1:0]  c0, colbase, col_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width    <= 10'd256;
            r_src_height   <= 10'd240;
            r_frame_enable <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_SRC_WIDTH:    r_src_width    <= i_cfg_data;
                CFG_SRC_HEIGHT:   r_src_height   <= i_cfg_data;
                CFG_FRAME_ENABLE: r_frame_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        is_pixel  = (t_opcode'(i_opcode) == OP_PIXEL);
        in_height = (r_row < r_src_height);
        col_ok    = (r_col < r_src_width);
        vdbl      = ({1'b0, r_src_height, 1'b0} <= 12'(FRAME_HEIGHT));
        hdbl      = ({1'b0, r_src_width, 1'b0} <= 12'(FRAME_WIDTH));
        fits      = ({1'b0, r_src_width} <= 11'(FRAME_WIDTH));
        frow      = vdbl ? {r_row, 1'b0} : {1'b0, r_row};
        frow_next = {1'b0, frow} + 12'd1;
        // drop rows past the bottom of the frame
        nrows     = 2'd0;
        if (frow < FROW_W'(FRAME_HEIGHT)) begin
            nrows = (vdbl && frow_next < 12'(FRAME_HEIGHT)) ? 2'd2 : 2'd1;
        end
        nwr       = hdbl ? {nrows, 1'b0} : {1'b0, nrows};
        c0        = DIM_W'((11'(FRAME_WIDTH) - {1'b0, r_src_width}) >> 1);
        colbase   = hdbl ? {r_col[DIM_W-2:0], 1'b0} : c0 + r_col;
        col_inc   = r_col + 10'd1;

        n_col = r_col;
        n_row = r_row;
        if (i_accept) begin
            if (t_opcode'(i_opcode) == OP_SOF) begin
                n_col = '0;
                n_row = '0;
            end else if (is_pixel && in_height) begin
                if (!col_ok || col_inc >= r_src_width) begin
                    n_col = '0;
                    n_row = r_row + 10'd1;
                end else begin
                    n_col = col_inc;
                end
            end
        end

        o_job_valid = i_accept && is_pixel && in_height && col_ok && r_frame_enable
                      && (hdbl || fits) && (nrows != 2'd0);
        o_job.frow       = frow;
        o_job.colbase    = colbase;
        o_job.hdbl       = hdbl;
        o_job.nwr        = nwr;
        o_job.zero_color = ({1'b0, i_pixel_code} >= 9'(PALETTE_DEPTH));

        o_pal_req.we    = i_accept && (t_opcode'(i_opcode) == OP_PAL_WRITE)
                          && ({1'b0, i_entry_index} < 9'(PALETTE_DEPTH));
        o_pal_req.waddr = i_entry_index;
        o_pal_req.wdata = i_entry_color;
        o_pal_req.re    = o_job_valid;
        o_pal_req.raddr = i_pixel_code;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

/* rtl/core/ppd_emitter.sv */
`timescale 1ns / 1ps

module ppd_emitter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  ppd_pkg::t_job i_job,
    input  logic [15:0]   i_rdata,
    input  logic          i_stall,
    output logic          o_ready,
    output logic          o_valid,
    output logic [16:0]   o_fb_offset,
    output logic [15:0]   o_pixel_color,
    output logic          o_last
);
    import ppd_pkg::*;

    logic               r_s1_valid;
    t_job               r_s1_job;
    logic               r_e_valid;
    logic [BASE_W-1:0]  r_e_base;
    logic [COLOR_W-1:0] r_e_color;
    logic               r_e_hdbl;
    logic [2:0]         r_e_n;
    logic [1:0]         r_e_k;

    logic              e_last, e_done, e_free, s1_move, dx, dy;
    logic [BASE_W-1:0] s1_base, offset;

    always_comb begin
        e_last  = ({1'b0, r_e_k} == r_e_n - 3'd1);
        e_done  = r_e_valid && !i_stall && e_last;
        e_free  = !r_e_valid || e_done;
        s1_move = r_s1_valid && e_free;
        o_ready = !r_s1_valid || s1_move;
        s1_base = BASE_W'(r_s1_job.frow) * BASE_W'(FRAME_WIDTH)
                  + BASE_W'(r_s1_job.colbase);
        // doubling walks (r,x) (r,x+1) (r+1,x) (r+1,x+1); centred walks rows only
        dx      = r_e_hdbl ? r_e_k[0] : 1'b0;
        dy      = r_e_hdbl ? r_e_k[1] : r_e_k[0];
        offset  = r_e_base + (dy ? BASE_W'(FRAME_WIDTH) : '0) + BASE_W'(dx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_e_valid  <= 1'b0;
            r_e_k      <= '0;
        end else begin
            if (i_job_valid) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_e_valid <= 1'b1;
                r_e_k     <= '0;
            end else if (e_done) begin
                r_e_valid <= 1'b0;
            end else if (r_e_valid && !i_stall) begin
                r_e_k <= r_e_k + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_job_valid) begin
            r_s1_job <= i_job;
        end
        if (s1_move) begin
            r_e_base  <= s1_base;
            r_e_color <= r_s1_job.zero_color ? '0 : i_rdata;
            r_e_hdbl  <= r_s1_job.hdbl;
            r_e_n     <= r_s1_job.nwr;
        end
    end

    assign o_valid       = r_e_valid;
    assign o_fb_offset   = offset[OFFSET_W-1:0];
    assign o_pixel_color = r_e_color;
    assign o_last        = e_last;

endmodule

/* rtl/core/palette_pixel_doubler_core.sv */
`timescale 1ns / 1ps

// Palette lookup with 2x pixel scaling into a 320x240 RGB565 framebuffer. Input words
// carry palette writes, 8-bit source pixel codes in row order, or a start of frame that
// clears the row and column counters. Each pixel becomes up to four framebuffer writes,
// one per cycle while the output is not stalled: doubled horizontally at the left edge
// when twice the source width fits, centred when only the width fits, and repeated on
// the next frame row when twice the source height fits. Input words are taken while a
// pixel's writes go out, until one more pixel waits behind it. The palette sits in a
// 256-entry memory with a registered read that is held until the pixel moves on, so a
// palette write is seen by the very next pixel. The configuration port is always ready;
// write it only while no pixel is in flight.
module palette_pixel_doubler_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_entry_index,
    input  logic [15:0] i_entry_color,
    input  logic [7:0]  i_pixel_code,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [16:0] o_fb_offset,
    output logic [15:0] o_pixel_color,
    output logic        o_last
);
    import ppd_pkg::*;

    logic               ready, accept, job_valid;
    t_pal_req           pal_req;
    t_job               job;
    logic [COLOR_W-1:0] rdata;

    assign o_stall     = !ready;
    assign accept      = i_valid && ready;
    assign o_cfg_ready = 1'b1;

    ppd_sequencer u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_opcode      (i_opcode),
        .i_entry_index (i_entry_index),
        .i_entry_color (i_entry_color),
        .i_pixel_code  (i_pixel_code),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_pal_req     (pal_req),
        .o_job_valid   (job_valid),
        .o_job         (job)
    );

    ppd_palette_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (pal_req),
        .o_rdata (rdata)
    );

    ppd_emitter u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (job_valid),
        .i_job         (job),
        .i_rdata       (rdata),
        .i_stall       (i_stall),
        .o_ready       (ready),
        .o_valid       (o_valid),
        .o_fb_offset   (o_fb_offset),
        .o_pixel_color (o_pixel_color),
        .o_last        (o_last)
    );

endmodule
